// ===== rtl/packet_duplicate_cache_defines.svh =====
// -----------------------------------------------------------------------------
// Packet duplicate cache assertion macros
// Shared assertion macros for the duplicate packet filter.
// -----------------------------------------------------------------------------
`ifndef PACKET_DUPLICATE_CACHE_DEFINES_SVH
`define PACKET_DUPLICATE_CACHE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PDC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PDC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define PDC_ASSERT(lbl, prop, msg)
`define PDC_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/pdc_pkg.sv =====
// -----------------------------------------------------------------------------
// Packet duplicate cache package
// Sizes, types and status records shared by the duplicate packet filter.
// -----------------------------------------------------------------------------
package pdc_pkg;

	localparam int CACHE_DEPTH  = 64;
	localparam int ID_WIDTH     = 16;
	localparam int SERIAL_WIDTH = 32;
	localparam int CFG_WIDTH    = 7;
	localparam int CFG_RESET    = 64;

	localparam int IDX_WIDTH    = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
	localparam int CNT_WIDTH    = $clog2(CACHE_DEPTH + 1);
	localparam int SIZE_WIDTH   = (CFG_WIDTH > CNT_WIDTH) ? CFG_WIDTH : CNT_WIDTH;
	localparam int ENTRY_WIDTH  = ID_WIDTH + SERIAL_WIDTH;

	typedef logic [ID_WIDTH-1:0]     id_t;
	typedef logic [SERIAL_WIDTH-1:0] serial_t;
	typedef logic [CFG_WIDTH-1:0]    cfg_t;
	typedef logic [CNT_WIDTH-1:0]    cnt_t;
	typedef logic [IDX_WIDTH-1:0]    idx_t;
	typedef logic [ENTRY_WIDTH-1:0]  entry_t;

	typedef struct packed {
		logic valid;
		logic seen;
	} res_t;

	typedef struct packed {
		logic idle;
		cnt_t fill_count;
	} stat_t;

endpackage

// ===== rtl/pdc_ifs.sv =====
// -----------------------------------------------------------------------------
// Packet duplicate cache channels
// Valid/ready channels for packets, verdicts and the size register.
// -----------------------------------------------------------------------------
interface pdc_in_if;
	import pdc_pkg::*;

	logic    valid;
	logic    ready;
	id_t     sender_id;
	serial_t serial_number;

	modport source (output valid, output sender_id, output serial_number, input ready);
	modport sink (input valid, input sender_id, input serial_number, output ready);
endinterface

interface pdc_out_if;
	logic valid;
	logic ready;
	logic seen_before;

	modport source (output valid, output seen_before, input ready);
	modport sink (input valid, input seen_before, output ready);
endinterface

interface pdc_cfg_if;
	import pdc_pkg::*;

	logic valid;
	logic ready;
	cfg_t cache_size;

	modport source (output valid, output cache_size, input ready);
	modport sink (input valid, input cache_size, output ready);
endinterface

// ===== rtl/pdc_ram.sv =====
// -----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// -----------------------------------------------------------------------------
module pdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/pdc_scan.sv =====
// -----------------------------------------------------------------------------
// Packet duplicate cache sequencer
// Walks the filled entries through one comparator, then records a new pair on a miss.
// -----------------------------------------------------------------------------
module pdc_scan (
	input  logic            clk,
	input  logic            arst_n,
	pdc_in_if.sink          pkt,
	input  pdc_pkg::cfg_t   cache_size,
	output pdc_pkg::res_t   res,
	input  logic            res_take,
	output pdc_pkg::stat_t  stat,
	output logic            rd_en,
	output pdc_pkg::idx_t   rd_addr,
	input  pdc_pkg::entry_t rd_data,
	output logic            wr_en,
	output pdc_pkg::idx_t   wr_addr,
	output pdc_pkg::entry_t wr_data
);
	import pdc_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]            state_q;
	entry_t                key_q;
	cnt_t                  idx_q;
	logic                  cmp_vld_q;
	logic                  seen_q;
	cnt_t                  fill_q;
	idx_t                  oldest_q;

	logic [SIZE_WIDTH-1:0] cfg_ext;
	cnt_t                  size_c;
	logic                  full_c;
	cnt_t                  oldest_ext;
	cnt_t                  slot_c;
	cnt_t                  next_c;
	idx_t                  oldest_next;
	logic                  hit_c;

	always_comb begin
		cfg_ext = SIZE_WIDTH'(cache_size);
		if (cfg_ext == '0) begin
			size_c = CNT_WIDTH'(1);
		end else if (cfg_ext > SIZE_WIDTH'(CACHE_DEPTH)) begin
			size_c = CNT_WIDTH'(CACHE_DEPTH);
		end else begin
			size_c = CNT_WIDTH'(cfg_ext);
		end
	end

	always_comb begin
		full_c      = (fill_q >= size_c);
		oldest_ext  = CNT_WIDTH'(oldest_q);
		slot_c      = (oldest_ext >= size_c) ? '0 : oldest_ext;
		next_c      = slot_c + CNT_WIDTH'(1);
		oldest_next = (next_c >= size_c) ? '0 : IDX_WIDTH'(next_c);
	end

	assign rd_en   = (state_q == ST_SCAN) && (idx_q < fill_q);
	assign rd_addr = IDX_WIDTH'(idx_q);
	assign hit_c   = cmp_vld_q && (rd_data == key_q);

	assign wr_en   = (state_q == ST_WRITE);
	assign wr_addr = full_c ? IDX_WIDTH'(slot_c) : IDX_WIDTH'(fill_q);
	assign wr_data = key_q;

	assign pkt.ready       = (state_q == ST_IDLE);
	assign res.valid       = (state_q == ST_DONE);
	assign res.seen        = seen_q;
	assign stat.idle       = (state_q == ST_IDLE);
	assign stat.fill_count = fill_q;

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			key_q <= {pkt.sender_id, pkt.serial_number};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			cmp_vld_q <= 1'b0;
			seen_q    <= 1'b0;
			fill_q    <= '0;
			oldest_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pkt.valid) begin
						idx_q     <= '0;
						cmp_vld_q <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cmp_vld_q <= rd_en;
					if (rd_en) begin
						idx_q <= idx_q + CNT_WIDTH'(1);
					end
					if (hit_c) begin
						seen_q    <= 1'b1;
						cmp_vld_q <= 1'b0;
						state_q   <= ST_DONE;
					end else if (!rd_en && !cmp_vld_q) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (full_c) begin
						oldest_q <= oldest_next;
					end else begin
						fill_q <= fill_q + CNT_WIDTH'(1);
					end
					seen_q  <= 1'b0;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== rtl/packet_duplicate_cache.sv =====
// -----------------------------------------------------------------------------
// Packet duplicate cache
// Duplicate packet filter with first-in first-out replacement of cached pairs.
//
//   Channel  Dir  Payload                      Transfer
//   pkt      in   sender_id, serial_number     one per packet checked
//   verdict  out  seen_before                  one per packet checked
//   cfg      in   cache_size                   one per size register write
//
// A packet holds pkt from its transfer until its verdict is registered, and
// its walk covers fill entries, the number of cached entries: the entries are
// read one a cycle through the single read port of the cache RAM and checked
// by one comparator. A match ends the walk early. A miss then writes the pair.
// No clearing pass follows reset; only filled entries are ever read.
// The verdict register lets a new packet start while the last verdict waits.
// -----------------------------------------------------------------------------
`include "packet_duplicate_cache_defines.svh"

module packet_duplicate_cache (
	input  logic       clk,
	input  logic       arst_n,
	pdc_in_if.sink     pkt,
	pdc_out_if.source  verdict,
	pdc_cfg_if.sink    cfg
);
	import pdc_pkg::*;

	cfg_t   size_q;
	res_t   res;
	stat_t  stat;
	logic   take;
	logic   out_valid_q;
	logic   out_seen_q;
	logic   rd_en;
	idx_t   rd_addr;
	entry_t rd_data;
	logic   wr_en;
	idx_t   wr_addr;
	entry_t wr_data;

	pdc_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.pkt        (pkt),
		.cache_size (size_q),
		.res        (res),
		.res_take   (take),
		.stat       (stat),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	pdc_ram #(
		.WIDTH (ENTRY_WIDTH),
		.DEPTH (CACHE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign cfg.ready = stat.idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= CFG_WIDTH'(CFG_RESET);
		end else if (cfg.valid && cfg.ready) begin
			size_q <= cfg.cache_size;
		end
	end

	assign take                = res.valid && (!out_valid_q || verdict.ready);
	assign verdict.valid       = out_valid_q;
	assign verdict.seen_before = out_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_seen_q  <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
			out_seen_q  <= res.seen;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	`PDC_NEVER(a_fill_bound, stat.fill_count > CNT_WIDTH'(CACHE_DEPTH), "fill count beyond depth")
	`PDC_ASSERT(a_fill_grows, stat.fill_count >= $past(stat.fill_count), "fill count shrank")
	`PDC_ASSERT(a_no_early_res, pkt.valid && pkt.ready |=> !res.valid, "verdict before any compare")
	`PDC_ASSERT(a_res_held, res.valid && !take |=> res.valid, "verdict dropped while blocked")

endmodule
